@@ hdl/ber_tlv_stream_parser_macros.svh @@
// assertion macros for the tlv parser
`ifndef BER_TLV_STREAM_PARSER_MACROS_SVH
`define BER_TLV_STREAM_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold on every clock edge out of reset
`define BTSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition must never be seen out of reset
`define BTSP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define BTSP_ASSERT(lbl, clk, rst_n, prop, msg)

`define BTSP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hdl/btsp_pkg.sv @@
`timescale 1ns / 1ps

package btsp_pkg;

	// default limits
	localparam int DEF_MAX_DEPTH        = 8;
	localparam int DEF_MAX_LENGTH_BYTES = 4;
	localparam int DEF_MAX_TAG_GROUPS   = 4;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// width of the depth seen by status and checks (holds up to 63)
	localparam int DEPTH_STAT_W = 6;

	// byte codes
	localparam logic [4:0] TAG_LONG_MARK = 5'h1F;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_ERROR  = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		ERR_TAG_LONG = 2'd0,
		ERR_LEN_LONG = 2'd1,
		ERR_DEPTH    = 2'd2,
		ERR_OVERRUN  = 2'd3
	} error_code_t;

	typedef enum logic [2:0] {
		PH_TAG_FIRST = 3'd0,
		PH_TAG_MORE  = 3'd1,
		PH_LEN_FIRST = 3'd2,
		PH_LEN_MORE  = 3'd3,
		PH_VALUE     = 3'd4
	} phase_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        frame_start;
		logic        long_tag;
		logic        short_len;
		logic [31:0] pos;
		logic [32:0] pos_next;
	} item_t;

	// one result item
	typedef struct packed {
		result_kind_t kind;
		logic [27:0]  tag;
		logic [1:0]   cls;
		logic         cons;
		logic [31:0]  len;
		logic [3:0]   lvl;
		logic [7:0]   vbyte;
		error_code_t  ecode;
	} result_t;

	// back end status
	typedef struct packed {
		logic                    ready;
		logic [DEPTH_STAT_W-1:0] depth;
	} back_stat_t;

endpackage

@@ hdl/btsp_front.sv @@
`timescale 1ns / 1ps

module btsp_front import btsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	output item_t      item
);

	logic [31:0] pos_q;
	logic [31:0] item_pos;

	// stamp position within the frame and classify the byte
	always_comb begin
		item_pos       = frame_start ? 32'd0 : pos_q;
		item.data      = data_byte;
		item.frame_start = frame_start;
		item.long_tag  = (data_byte[4:0] == TAG_LONG_MARK);
		item.short_len = !data_byte[7];
		item.pos       = item_pos;
		item.pos_next  = {1'b0, item_pos} + 33'd1;
	end

	// next position counter, wraps modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= item.pos_next[31:0];
		end
	end

endmodule

@@ hdl/btsp_fifo.sv @@
`timescale 1ns / 1ps

module btsp_fifo import btsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	input  logic  pop,
	output logic  full,
	output logic  valid,
	output item_t rd_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_item = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/btsp_back.sv @@
`timescale 1ns / 1ps

module btsp_back import btsp_pkg::*; #(
	parameter int MAX_DEPTH        = DEF_MAX_DEPTH,
	parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES,
	parameter int MAX_TAG_GROUPS   = DEF_MAX_TAG_GROUPS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  item_t      item,
	input  logic       out_stall,
	output back_stat_t stat,
	output logic       res_valid,
	output result_t    res
);

	localparam int DEP_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int TGC_W = $clog2(MAX_TAG_GROUPS + 1);
	localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 1);

	phase_t           phase_q, phase_d, phase_e;
	logic [27:0]      tacc_q, tacc_d, tacc_e;
	logic [2:0]       ftb_q, ftb_d, ftb_e;
	logic [TGC_W-1:0] tgc_q, tgc_d, tgc_e;
	logic [31:0]      lacc_q, lacc_d, lacc_e;
	logic [LBL_W-1:0] lleft_q, lleft_d, lleft_e;
	logic [DEP_W-1:0] dep_q, dep_d, dep_e;
	logic [31:0]      vend_q, vend_d, vend_e;
	logic [31:0]      stack_q [MAX_DEPTH];

	logic             out_vld_q;
	result_t          res_q;
	result_t          res_n;
	logic             res_v;

	logic             ready;
	logic             take;
	logic [7:0]       b;
	logic [6:0]       cnt;
	logic [DEP_W-1:0] pop_dep;
	logic [DEP_W-1:0] dep_m1;
	logic [31:0]      top_end;
	logic [31:0]      hdr_len;
	logic [32:0]      end33;
	logic             overrun;
	logic             too_deep;
	logic             fin;
	logic             err;
	error_code_t      ecode;
	logic             push;
	logic [TGC_W-1:0] tgc_inc;

	assign ready = !out_vld_q || !out_stall;
	assign take  = item_valid && ready;
	assign b     = item.data;
	assign cnt   = item.data[6:0];

	// frame start returns the parser to the top level before the byte
	always_comb begin
		if (item.frame_start) begin
			phase_e = PH_TAG_FIRST;
			tacc_e  = '0;
			ftb_e   = '0;
			tgc_e   = '0;
			lacc_e  = '0;
			lleft_e = '0;
			dep_e   = '0;
			vend_e  = '0;
		end else begin
			phase_e = phase_q;
			tacc_e  = tacc_q;
			ftb_e   = ftb_q;
			tgc_e   = tgc_q;
			lacc_e  = lacc_q;
			lleft_e = lleft_q;
			dep_e   = dep_q;
			vend_e  = vend_q;
		end
	end

	// parallel pop: keep parents up to the highest one not yet finished
	always_comb begin
		pop_dep = '0;
		for (int k = 0; k < MAX_DEPTH; k++) begin
			if (DEP_W'(k) < dep_e && item.pos < stack_q[k]) begin
				pop_dep = DEP_W'(k + 1);
			end
		end
	end

	// header length, end position and checks against the innermost parent
	always_comb begin
		dep_m1  = dep_e - DEP_W'(1);
		top_end = stack_q[dep_m1[IDX_W-1:0]];
		if (phase_e == PH_LEN_MORE) begin
			hdr_len = {lacc_e[23:0], b};
		end else if (item.short_len) begin
			hdr_len = {24'd0, b};
		end else begin
			hdr_len = '0;
		end
		end33    = item.pos_next + {1'b0, hdr_len};
		overrun  = (dep_e != '0) && (end33 > {1'b0, top_end});
		too_deep = ftb_e[0] && (hdr_len != '0) && (dep_e >= DEP_W'(MAX_DEPTH));
		tgc_inc  = tgc_e + TGC_W'(1);
	end

	// next state and result
	always_comb begin
		phase_d = phase_e;
		tacc_d  = tacc_e;
		ftb_d   = ftb_e;
		tgc_d   = tgc_e;
		lacc_d  = lacc_e;
		lleft_d = lleft_e;
		dep_d   = dep_e;
		vend_d  = vend_e;
		res_v   = 1'b0;
		res_n   = '0;
		fin     = 1'b0;
		err     = 1'b0;
		ecode   = ERR_TAG_LONG;
		push    = 1'b0;

		unique case (phase_e)
			PH_TAG_FIRST: begin
				dep_d = pop_dep;
				ftb_d = b[7:5];
				if (item.long_tag) begin
					tacc_d  = '0;
					tgc_d   = '0;
					phase_d = PH_TAG_MORE;
				end else begin
					tacc_d  = {20'd0, b};
					phase_d = PH_LEN_FIRST;
				end
			end
			PH_TAG_MORE: begin
				tacc_d = {tacc_e[20:0], b[6:0]};
				tgc_d  = tgc_inc;
				if (b[7]) begin
					if (tgc_inc >= TGC_W'(MAX_TAG_GROUPS)) begin
						err   = 1'b1;
						ecode = ERR_TAG_LONG;
					end
				end else begin
					phase_d = PH_LEN_FIRST;
				end
			end
			PH_LEN_FIRST: begin
				if (item.short_len || cnt == 7'd0) begin
					fin = 1'b1;
				end else if (cnt > 7'(MAX_LENGTH_BYTES)) begin
					err   = 1'b1;
					ecode = ERR_LEN_LONG;
				end else begin
					lacc_d  = '0;
					lleft_d = LBL_W'(cnt);
					phase_d = PH_LEN_MORE;
				end
			end
			PH_LEN_MORE: begin
				if (lacc_e[31:24] != 8'd0) begin
					err   = 1'b1;
					ecode = ERR_LEN_LONG;
				end else begin
					lacc_d  = {lacc_e[23:0], b};
					lleft_d = lleft_e - LBL_W'(1);
					if (lleft_e == LBL_W'(1)) begin
						fin = 1'b1;
					end
				end
			end
			PH_VALUE: begin
				res_v       = 1'b1;
				res_n.kind  = KIND_VALUE;
				res_n.vbyte = b;
				if (item.pos_next[31:0] == vend_e) begin
					phase_d = PH_TAG_FIRST;
				end
			end
			default: begin
				phase_d = PH_TAG_FIRST;
				tacc_d  = '0;
				ftb_d   = '0;
				tgc_d   = '0;
				lacc_d  = '0;
				lleft_d = '0;
				dep_d   = '0;
				vend_d  = '0;
			end
		endcase

		// header complete: check, report, then open the content
		if (fin) begin
			if (overrun) begin
				err   = 1'b1;
				ecode = ERR_OVERRUN;
			end else if (too_deep) begin
				err   = 1'b1;
				ecode = ERR_DEPTH;
			end else begin
				res_v      = 1'b1;
				res_n.kind = KIND_HEADER;
				res_n.tag  = tacc_e;
				res_n.cls  = ftb_e[2:1];
				res_n.cons = ftb_e[0];
				res_n.len  = hdr_len;
				res_n.lvl  = 4'(dep_e);
				phase_d    = PH_TAG_FIRST;
				if (hdr_len != '0) begin
					if (ftb_e[0]) begin
						push  = 1'b1;
						dep_d = dep_e + DEP_W'(1);
					end else begin
						vend_d  = end33[31:0];
						phase_d = PH_VALUE;
					end
				end
			end
		end

		// error: byte consumed, back to top level
		if (err) begin
			res_v       = 1'b1;
			res_n       = '0;
			res_n.kind  = KIND_ERROR;
			res_n.ecode = ecode;
			phase_d     = PH_TAG_FIRST;
			tacc_d      = '0;
			ftb_d       = '0;
			tgc_d       = '0;
			lacc_d      = '0;
			lleft_d     = '0;
			dep_d       = '0;
			vend_d      = '0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG_FIRST;
			tacc_q  <= '0;
			ftb_q   <= '0;
			tgc_q   <= '0;
			lacc_q  <= '0;
			lleft_q <= '0;
			dep_q   <= '0;
			vend_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			tacc_q  <= tacc_d;
			ftb_q   <= ftb_d;
			tgc_q   <= tgc_d;
			lacc_q  <= lacc_d;
			lleft_q <= lleft_d;
			dep_q   <= dep_d;
			vend_q  <= vend_d;
		end
	end

	// end position stack
	always_ff @(posedge clk) begin
		if (take && push) begin
			stack_q[dep_e[IDX_W-1:0]] <= end33[31:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ready) begin
			out_vld_q <= take && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_v) begin
			res_q <= res_n;
		end
	end

	assign res_valid  = out_vld_q;
	assign res        = res_q;
	assign stat.ready = ready;
	assign stat.depth = DEPTH_STAT_W'(dep_q);

endmodule

@@ hdl/ber_tlv_stream_parser.sv @@
`timescale 1ns / 1ps
// BER-TLV stream parser.
// Input channel: one byte of the encoded stream per request on data_byte, with
// frame_start high on the first byte of a frame; accepted when in_valid is high
// and in_stall is low. Output channel: at most one result per byte (object
// header, primitive value byte or error), accepted when out_valid is high and
// out_stall is low. Bytes that only advance the decoder give no result.
// Each byte passes through the two-entry queue, and the parser registers its
// result in the output register that drives the output channel.
// Throughput: one byte per cycle sustained while out_stall is low; each byte is
// decoded in one parser pass, with the parallel pop of finished parents off the stack.
// Reset clears the queue, the position counter and the parser, which then
// expects a top-level tag; in_stall is low straight after reset.
// When the receiver stalls, the output register holds its result, the queue
// takes up to two more bytes and then in_stall rises until results drain.
// Nesting is tracked on an end-position stack of MAX_DEPTH entries.

`include "ber_tlv_stream_parser_macros.svh"

module ber_tlv_stream_parser import btsp_pkg::*; #(
	parameter int MAX_DEPTH        = DEF_MAX_DEPTH,
	parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES,
	parameter int MAX_TAG_GROUPS   = DEF_MAX_TAG_GROUPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [27:0] tag_number,
	output logic [1:0]  tag_class,
	output logic        is_constructed,
	output logic [31:0] object_length,
	output logic [3:0]  nesting_level,
	output logic [7:0]  value_byte,
	output logic [1:0]  error_code
);

	item_t      f_item;
	item_t      q_item;
	logic       q_full;
	logic       q_valid;
	logic       q_push;
	logic       q_pop;
	back_stat_t stat;
	result_t    res;

	assign q_push   = in_valid && !q_full;
	assign q_pop    = q_valid && stat.ready;
	assign in_stall = q_full;

	// byte classification and position stamping
	btsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (q_push),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.item        (f_item)
	);

	// decoupling queue
	btsp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (f_item),
		.pop     (q_pop),
		.full    (q_full),
		.valid   (q_valid),
		.rd_item (q_item)
	);

	// tlv decoder with output register
	btsp_back #(
		.MAX_DEPTH        (MAX_DEPTH),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
		.MAX_TAG_GROUPS   (MAX_TAG_GROUPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.out_stall  (out_stall),
		.stat       (stat),
		.res_valid  (out_valid),
		.res        (res)
	);

	// result fields
	assign result_kind    = res.kind;
	assign tag_number     = res.tag;
	assign tag_class      = res.cls;
	assign is_constructed = res.cons;
	assign object_length  = res.len;
	assign nesting_level  = res.lvl;
	assign value_byte     = res.vbyte;
	assign error_code     = res.ecode;

	// checks
	`BTSP_ASSERT_NEVER(a_depth_limit, clk, arst_n, stat.depth > DEPTH_STAT_W'(MAX_DEPTH), "stack depth above limit")
	`BTSP_ASSERT(a_frame_top, clk, arst_n, q_pop && q_item.frame_start |=> stat.depth == '0, "frame start left parents open")
	`BTSP_ASSERT(a_error_top, clk, arst_n, out_valid && result_kind == KIND_ERROR && $past(q_pop) |-> stat.depth == '0, "error result left parents open")

endmodule
